// ===== rtl/core/losf_pkg.sv =====
// losf_pkg: shared sizes, widths and types for the largest ones square finder
// depends on nothing; used by largest_ones_square_finder_top and its test bench
package losf_pkg;

	// line buffer depth and frame height limits
	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;

	// counter and clamped dimension widths
	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
	localparam int ROWS_W = $clog2(MAX_ROWS + 1);

	// a square side never exceeds the smaller dimension
	localparam int MIN_DIM = (MAX_COLUMNS < MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
	localparam int SIZE_W  = $clog2(MIN_DIM + 1);

	// fixed field widths
	localparam int CFG_W     = 11;
	localparam int OUT_SIZE_W = 11;
	localparam int OUT_POS_W  = 10;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// register indexes
	localparam logic REG_FRAME_COLUMNS = 1'b0;
	localparam logic REG_FRAME_ROWS    = 1'b1;

	typedef logic [COL_W-1:0]      col_t;
	typedef logic [ROW_W-1:0]      row_t;
	typedef logic [COLS_W:0]       cols_cmp_t;
	typedef logic [ROWS_W:0]       rows_cmp_t;
	typedef logic [COLS_W-1:0]     cols_t;
	typedef logic [ROWS_W-1:0]     rows_t;
	typedef logic [SIZE_W-1:0]     size_t;
	typedef logic [CFG_W-1:0]      cfg_t;
	typedef logic [OUT_SIZE_W-1:0] out_size_t;
	typedef logic [OUT_POS_W-1:0]  out_pos_t;
	typedef logic [APB_DW-1:0]     apb_data_t;

	// clamp a column count register to 1..MAX_COLUMNS
	function automatic cols_t clamp_cols(cfg_t v);
		cols_t r;
		if (v == '0) begin
			r = cols_t'(1);
		end else if (v > MAX_COLUMNS) begin
			r = cols_t'(MAX_COLUMNS);
		end else begin
			r = cols_t'(v);
		end
		return r;
	endfunction

	// clamp a row count register to 1..MAX_ROWS
	function automatic rows_t clamp_rows(cfg_t v);
		rows_t r;
		if (v == '0) begin
			r = rows_t'(1);
		end else if (v > MAX_ROWS) begin
			r = rows_t'(MAX_ROWS);
		end else begin
			r = rows_t'(v);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/largest_ones_square_finder_top.sv =====
// largest_ones_square_finder_top: raster pixel stream in, one best square per frame out
// depends on losf_pkg; holds the line buffer memory and the apb register file
// the last pixel is registered at input, then its result in the result or skid register
// one pixel per cycle unless stalled; the line buffer read is prefetched one column ahead
// stalls: the input stalls only on the last pixel of a frame while two result beats wait
// reset: counters, tracking, edge sizes and valid flags clear, frame sizes return to 1024;
// the line buffer is not cleared, the first row writes each entry before its value is used
module largest_ones_square_finder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        pixel_bit,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output losf_pkg::out_size_t         best_size,
	output losf_pkg::out_pos_t          best_row,
	output losf_pkg::out_pos_t          best_col,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [losf_pkg::APB_AW-1:0] paddr,
	input  losf_pkg::apb_data_t         pwdata,
	output losf_pkg::apb_data_t         prdata,
	output logic                        pready
);

	losf_pkg::cfg_t  cols_cfg_q, rows_cfg_q;
	losf_pkg::cols_t cols_eff;
	losf_pkg::rows_t rows_eff;

	logic            pix_valid_s1, pix_s1;
	logic            go_s1;
	logic            res_load;
	logic            last_col, frame_end;

	losf_pkg::col_t  col_q, next_col, rd_addr;
	losf_pkg::row_t  row_q;
	losf_pkg::size_t left_q, diag_q, up_q;
	losf_pkg::size_t min_lu, min_all, size_now;
	losf_pkg::size_t best_size_q, best_size_nx;
	losf_pkg::row_t  best_row_q, best_row_nx;
	losf_pkg::col_t  best_col_q, best_col_nx;

	losf_pkg::size_t line_mem [losf_pkg::MAX_COLUMNS];

	logic            out_valid_q;
	losf_pkg::out_size_t out_size_q;
	losf_pkg::out_pos_t  out_row_q, out_col_q;
	logic            skid_valid_q;
	losf_pkg::out_size_t skid_size_q;
	losf_pkg::out_pos_t  skid_row_q, skid_col_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= losf_pkg::cfg_t'(losf_pkg::MAX_COLUMNS);
			rows_cfg_q <= losf_pkg::cfg_t'(losf_pkg::MAX_ROWS);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				losf_pkg::REG_FRAME_COLUMNS: cols_cfg_q <= pwdata[losf_pkg::CFG_W-1:0];
				losf_pkg::REG_FRAME_ROWS:    rows_cfg_q <= pwdata[losf_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			losf_pkg::REG_FRAME_COLUMNS: prdata = losf_pkg::apb_data_t'(cols_cfg_q);
			losf_pkg::REG_FRAME_ROWS:    prdata = losf_pkg::apb_data_t'(rows_cfg_q);
			default:                     prdata = '0;
		endcase
	end

	assign cols_eff = losf_pkg::clamp_cols(cols_cfg_q);
	assign rows_eff = losf_pkg::clamp_rows(rows_cfg_q);

	// row and frame boundaries of the pixel in the processing stage
	assign last_col  = (losf_pkg::cols_cmp_t'(col_q) + 1'b1) >= losf_pkg::cols_cmp_t'(cols_eff);
	assign frame_end = last_col &&
		((losf_pkg::rows_cmp_t'(row_q) + 1'b1) >= losf_pkg::rows_cmp_t'(rows_eff));

	// the stage moves unless a frame result finds both result slots full
	assign go_s1    = pix_valid_s1 && !(frame_end && skid_valid_q);
	assign in_stall = pix_valid_s1 && !go_s1;
	assign res_load = go_s1 && frame_end;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s1 <= 1'b0;
			pix_s1       <= 1'b0;
		end else if (!in_stall) begin
			pix_valid_s1 <= in_valid;
			pix_s1       <= pixel_bit;
		end
	end

	// square side ending at the current pixel
	always_comb begin
		min_lu  = (left_q < up_q) ? left_q : up_q;
		min_all = (min_lu < diag_q) ? min_lu : diag_q;
		if (row_q == '0 || col_q == '0) begin
			size_now = losf_pkg::size_t'(pix_s1);
		end else if (!pix_s1) begin
			size_now = '0;
		end else begin
			size_now = min_all + 1'b1;
		end
	end

	// running best, first in raster order wins ties
	always_comb begin
		best_size_nx = best_size_q;
		best_row_nx  = best_row_q;
		best_col_nx  = best_col_q;
		if (size_now > best_size_q) begin
			best_size_nx = size_now;
			best_row_nx  = row_q;
			best_col_nx  = col_q;
		end
	end

	// prefetch address: the column of the next pixel to be processed
	assign next_col = last_col ? '0 : col_q + 1'b1;
	assign rd_addr  = go_s1 ? next_col : col_q;

	// line buffer of sizes from the row above
	always_ff @(posedge clk) begin
		if (go_s1) begin
			line_mem[col_q] <= size_now;
		end
		up_q <= line_mem[rd_addr];
	end

	// position counters, neighbor sizes and tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (go_s1) begin
			col_q <= next_col;
			if (last_col) begin
				left_q <= '0;
				diag_q <= '0;
			end else begin
				left_q <= size_now;
				diag_q <= up_q;
			end
			if (frame_end) begin
				row_q       <= '0;
				best_size_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				if (last_col) begin
					row_q <= row_q + 1'b1;
				end
				best_size_q <= best_size_nx;
				best_row_q  <= best_row_nx;
				best_col_q  <= best_col_nx;
			end
		end
	end

	// result register and skid slot, one beat per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q  <= skid_valid_q || res_load;
			skid_valid_q <= 1'b0;
		end else if (res_load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_size_q <= skid_size_q;
				out_row_q  <= skid_row_q;
				out_col_q  <= skid_col_q;
			end else if (res_load) begin
				out_size_q <= losf_pkg::out_size_t'(best_size_nx);
				out_row_q  <= losf_pkg::out_pos_t'(best_row_nx);
				out_col_q  <= losf_pkg::out_pos_t'(best_col_nx);
			end
		end else if (res_load) begin
			skid_size_q <= losf_pkg::out_size_t'(best_size_nx);
			skid_row_q  <= losf_pkg::out_pos_t'(best_row_nx);
			skid_col_q  <= losf_pkg::out_pos_t'(best_col_nx);
		end
	end

	assign out_valid = out_valid_q;
	assign best_size = out_size_q;
	assign best_row  = out_row_q;
	assign best_col  = out_col_q;

`ifndef ASSERT_OFF
	// tracking and position clear after the last pixel of a frame
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && frame_end |=> best_size_q == '0 && row_q == '0 && col_q == '0)
		else $error("tracking not cleared at frame end");

	// a left neighbor side never exceeds the column index
	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= losf_pkg::size_t'(col_q))
		else $error("left size exceeds column index");

	// input is held back only by a frame result with both slots full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> pix_valid_s1 && frame_end && skid_valid_q)
		else $error("input stalled without a blocked frame result");

	// the skid slot only fills behind a held result
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full with result register empty");

	// a result beat appears only after a frame end was processed
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(go_s1 && frame_end))
		else $error("result beat without frame end");
`endif

endmodule

// ===== sim/largest_ones_square_finder_top_test.sv =====
// largest_ones_square_finder_top_test: self-checking bench for the largest ones square finder
// sets frame size over apb, streams raster frames and checks each per-frame result against
// a line-buffer tracker kept here; depends on losf_pkg and largest_ones_square_finder_top
module largest_ones_square_finder_top_test;

	localparam int RANDOM_PIXELS  = 630;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_LIMIT    = 800;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 10;

	typedef enum logic [2:0] {
		PAT_ZERO,
		PAT_ONE,
		PAT_CHECKER,
		PAT_LAST_ONLY,
		PAT_RANDOM
	} pattern_e;

	typedef struct packed {
		losf_pkg::out_size_t size;
		losf_pkg::out_pos_t  row;
		losf_pkg::out_pos_t  col;
	} square_t;

	typedef struct packed {
		losf_pkg::cfg_t cols_reg;
		losf_pkg::cfg_t rows_reg;
		pattern_e       pattern;
		logic           known;
		square_t        want;
	} frame_case_t;

	logic                rclk_unused_guard;
	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                pixel_bit;
	logic                out_valid;
	logic                out_stall;
	losf_pkg::out_size_t best_size;
	losf_pkg::out_pos_t  best_row;
	losf_pkg::out_pos_t  best_col;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [losf_pkg::APB_AW-1:0] paddr;
	losf_pkg::apb_data_t pwdata;
	losf_pkg::apb_data_t prdata;
	logic                pready;

	// tracker copy of the block state and its registers
	losf_pkg::cfg_t      cfg_columns;
	losf_pkg::cfg_t      cfg_rows;
	losf_pkg::out_size_t line_sizes [losf_pkg::MAX_COLUMNS];
	losf_pkg::out_size_t left_sz;
	losf_pkg::out_size_t diag_sz;
	losf_pkg::out_pos_t  col_pos;
	losf_pkg::out_pos_t  row_pos;
	losf_pkg::out_size_t run_best_size;
	losf_pkg::out_pos_t  run_best_row;
	losf_pkg::out_pos_t  run_best_col;

	square_t     pending_squares [$];
	square_t     last_square;
	frame_case_t directed_frames [$];
	int          error_count       = 0;
	int          result_index      = 0;
	int          quiet_cycles      = 0;
	logic        in_gaps           = 1'b1;
	logic        out_gaps          = 1'b1;
	logic        long_hold_pending = 1'b0;

	largest_ones_square_finder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_bit (pixel_bit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.best_size (best_size),
		.best_row  (best_row),
		.best_col  (best_col),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic compare_square(input string tag, input square_t got, input square_t want);
		if (got.size !== want.size) begin
			flag_error($sformatf("%s best_size %0d, want %0d", tag, got.size, want.size));
		end
		if (got.row !== want.row) begin
			flag_error($sformatf("%s best_row %0d, want %0d", tag, got.row, want.row));
		end
		if (got.col !== want.col) begin
			flag_error($sformatf("%s best_col %0d, want %0d", tag, got.col, want.col));
		end
	endtask

	// zero acts as one, anything past the limit acts as the limit
	function automatic int unsigned dim_clamp(input int unsigned v, input int unsigned limit);
		if (v == 0) begin
			return 1;
		end
		if (v > limit) begin
			return limit;
		end
		return v;
	endfunction

	task automatic reset_tracker();
		cfg_columns   = losf_pkg::cfg_t'(1024);
		cfg_rows      = losf_pkg::cfg_t'(1024);
		left_sz       = '0;
		diag_sz       = '0;
		col_pos       = '0;
		row_pos       = '0;
		run_best_size = '0;
		run_best_row  = '0;
		run_best_col  = '0;
		foreach (line_sizes[i]) begin
			line_sizes[i] = '0;
		end
	endtask

	// one pixel through the square-size recurrence; queues a square at frame end
	task automatic track_pixel(input logic pix);
		int unsigned cols, rows, col, up, size, smallest;
		square_t     done;
		cols = dim_clamp(cfg_columns, losf_pkg::MAX_COLUMNS);
		rows = dim_clamp(cfg_rows, losf_pkg::MAX_ROWS);
		col  = (col_pos < losf_pkg::MAX_COLUMNS) ? col_pos : losf_pkg::MAX_COLUMNS - 1;
		up   = line_sizes[col];
		if (row_pos == 0 || col == 0) begin
			size = pix;
		end else if (!pix) begin
			size = 0;
		end else begin
			smallest = left_sz;
			if (up < smallest) smallest = up;
			if (diag_sz < smallest) smallest = diag_sz;
			size = smallest + 1;
		end
		// strict compare keeps the first corner in raster order
		if (size > run_best_size) begin
			run_best_size = losf_pkg::out_size_t'(size);
			run_best_row  = row_pos;
			run_best_col  = losf_pkg::out_pos_t'(col);
		end
		diag_sz         = losf_pkg::out_size_t'(up);
		left_sz         = losf_pkg::out_size_t'(size);
		line_sizes[col] = losf_pkg::out_size_t'(size);
		if (col + 1 >= cols) begin
			col_pos = '0;
			left_sz = '0;
			diag_sz = '0;
			if (row_pos + 1 >= rows) begin
				done.size = run_best_size;
				done.row  = run_best_row;
				done.col  = run_best_col;
				pending_squares.push_back(done);
				row_pos       = '0;
				run_best_size = '0;
				run_best_row  = '0;
				run_best_col  = '0;
			end else begin
				row_pos = row_pos + 1'b1;
			end
		end else begin
			col_pos = losf_pkg::out_pos_t'(col + 1);
		end
	endtask

	// observe beats on all channels at the rising edge
	always @(posedge clk) begin : monitor
		square_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.size = best_size;
				got.row  = best_row;
				got.col  = best_col;
				if (pending_squares.size() == 0) begin
					flag_error($sformatf("result %0d with nothing expected", result_index));
				end else begin
					compare_square($sformatf("result %0d", result_index), got,
						pending_squares.pop_front());
				end
				last_square = got;
				result_index++;
			end
			if (in_valid && !in_stall) begin
				track_pixel(pixel_bit);
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == losf_pkg::REG_FRAME_COLUMNS) begin
					cfg_columns = pwdata[losf_pkg::CFG_W-1:0];
				end else begin
					cfg_rows = pwdata[losf_pkg::CFG_W-1:0];
				end
			end
		end
	end

	// watchdog on cycles with no pixel or result beat
	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stall bursts, one long hold on request
	initial begin : result_receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_pending) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				long_hold_pending = 1'b0;
			end else if (out_gaps && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one apb transfer, setup then access
	task automatic apb_access(input logic write, input logic reg_idx,
		input losf_pkg::apb_data_t data, output losf_pkg::apb_data_t rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= losf_pkg::APB_AW'({reg_idx, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write both dimensions with junk in the upper bits, then read them back
	task automatic set_frame_size(input int unsigned cols_reg, input int unsigned rows_reg);
		losf_pkg::apb_data_t data, readback;
		data = $urandom;
		data[losf_pkg::CFG_W-1:0] = losf_pkg::cfg_t'(cols_reg);
		apb_access(1'b1, losf_pkg::REG_FRAME_COLUMNS, data, readback);
		data = $urandom;
		data[losf_pkg::CFG_W-1:0] = losf_pkg::cfg_t'(rows_reg);
		apb_access(1'b1, losf_pkg::REG_FRAME_ROWS, data, readback);
		apb_access(1'b0, losf_pkg::REG_FRAME_COLUMNS, '0, readback);
		if (readback !== losf_pkg::apb_data_t'(losf_pkg::cfg_t'(cols_reg))) begin
			flag_error($sformatf("frame_columns reads %0h, want %0h", readback,
				losf_pkg::cfg_t'(cols_reg)));
		end
		apb_access(1'b0, losf_pkg::REG_FRAME_ROWS, '0, readback);
		if (readback !== losf_pkg::apb_data_t'(losf_pkg::cfg_t'(rows_reg))) begin
			flag_error($sformatf("frame_rows reads %0h, want %0h", readback,
				losf_pkg::cfg_t'(rows_reg)));
		end
	endtask

	// offer one pixel beat, maybe after an idle burst, and hold until taken
	task automatic push_pixel(input logic p);
		@(negedge clk);
		if (in_gaps && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		pixel_bit <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_frame(input pattern_e pat, input int unsigned cols,
		input int unsigned rows, input int unsigned density);
		int unsigned r, c;
		logic        p;
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < cols; c++) begin
				case (pat)
					PAT_ZERO:      p = 1'b0;
					PAT_ONE:       p = 1'b1;
					PAT_CHECKER:   p = ((r + c) % 2) == 0;
					PAT_LAST_ONLY: p = (r == rows - 1) && (c == cols - 1);
					default:       p = $urandom_range(0, 99) < density;
				endcase
				push_pixel(p);
			end
		end
	endtask

	// drop valid, wait for every queued square, then let the pipe settle
	task automatic close_phase();
		int unsigned waited;
		@(negedge clk);
		in_valid <= 1'b0;
		waited = 0;
		while (pending_squares.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_squares.size() != 0) begin
			flag_error($sformatf("%0d expected results never arrived", pending_squares.size()));
			pending_squares.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned cols_reg, input int unsigned rows_reg,
		input pattern_e pat, input int unsigned density, input int unsigned frames,
		output int unsigned pixels);
		int unsigned cols, rows;
		cols = dim_clamp(losf_pkg::cfg_t'(cols_reg), losf_pkg::MAX_COLUMNS);
		rows = dim_clamp(losf_pkg::cfg_t'(rows_reg), losf_pkg::MAX_ROWS);
		set_frame_size(cols_reg, rows_reg);
		repeat (frames) send_frame(pat, cols, rows, density);
		close_phase();
		pixels = cols * rows * frames;
	endtask

	task automatic add_case(input int unsigned cols_reg, input int unsigned rows_reg,
		input pattern_e pat, input logic known, input int unsigned size,
		input int unsigned row, input int unsigned col);
		frame_case_t fc;
		fc.cols_reg  = losf_pkg::cfg_t'(cols_reg);
		fc.rows_reg  = losf_pkg::cfg_t'(rows_reg);
		fc.pattern   = pat;
		fc.known     = known;
		fc.want.size = losf_pkg::out_size_t'(size);
		fc.want.row  = losf_pkg::out_pos_t'(row);
		fc.want.col  = losf_pkg::out_pos_t'(col);
		directed_frames.push_back(fc);
	endtask

	initial begin : stimulus
		int unsigned cols_reg, rows_reg, frames, density, pixels, random_pixels;
		int unsigned frame_pixels;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		pixel_bit = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		reset_tracker();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed frames: cols, rows, pattern, known square (size, row, col)
		add_case(1, 1, PAT_ZERO,      1'b1, 0, 0, 0);
		add_case(1, 1, PAT_ONE,       1'b1, 1, 0, 0);
		add_case(0, 0, PAT_ONE,       1'b1, 1, 0, 0);
		add_case(2, 2, PAT_ONE,       1'b1, 2, 1, 1);
		add_case(2, 2, PAT_ZERO,      1'b1, 0, 0, 0);
		add_case(3, 2, PAT_LAST_ONLY, 1'b1, 1, 1, 2);
		add_case(3, 1, PAT_ONE,       1'b1, 1, 0, 0);
		add_case(1, 3, PAT_ONE,       1'b1, 1, 0, 0);
		add_case(3, 3, PAT_ONE,       1'b1, 3, 2, 2);
		add_case(4, 3, PAT_ONE,       1'b1, 3, 2, 2);
		add_case(2, 2, PAT_CHECKER,   1'b1, 1, 0, 0);
		add_case(3, 3, PAT_RANDOM,    1'b0, 0, 0, 0);
		foreach (directed_frames[i]) begin
			run_phase(directed_frames[i].cols_reg, directed_frames[i].rows_reg,
				directed_frames[i].pattern, 70, 1, pixels);
			if (directed_frames[i].known) begin
				compare_square($sformatf("directed frame %0d", i), last_square,
					directed_frames[i].want);
			end
		end

		// backpressure: results held off while tiny frames keep coming
		set_frame_size(2, 2);
		in_gaps = 1'b0;
		long_hold_pending = 1'b1;
		repeat (40) send_frame(PAT_RANDOM, 2, 2, 70);
		close_phase();
		in_gaps = 1'b1;

		// random frames, mostly dense so squares grow; idling stops near the end
		random_pixels = 0;
		while (random_pixels < RANDOM_PIXELS) begin
			if (random_pixels + 150 > RANDOM_PIXELS) begin
				in_gaps  = 1'b0;
				out_gaps = 1'b0;
			end
			cols_reg = $urandom_range(1, 10);
			rows_reg = $urandom_range(1, 10);
			case ($urandom_range(0, 7))
				0: cols_reg = 0;
				1: rows_reg = 0;
				2: begin
					cols_reg = $urandom_range(11, 40);
					rows_reg = $urandom_range(1, 3);
				end
				default: ;
			endcase
			case ($urandom_range(0, 4))
				0:       density = 25;
				1:       density = 100;
				default: density = 90;
			endcase
			frames = $urandom_range(1, 4);
			frame_pixels = dim_clamp(losf_pkg::cfg_t'(cols_reg), losf_pkg::MAX_COLUMNS) *
				dim_clamp(losf_pkg::cfg_t'(rows_reg), losf_pkg::MAX_ROWS);
			while (frames > 1 && random_pixels + frame_pixels * frames > RANDOM_PIXELS) begin
				frames--;
			end
			run_phase(cols_reg, rows_reg, PAT_RANDOM, density, frames, pixels);
			random_pixels += pixels;
		end

		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== largest_ones_square_finder_top.f =====
rtl/core/losf_pkg.sv
rtl/core/largest_ones_square_finder_top.sv
sim/largest_ones_square_finder_top_test.sv
